@@ hw/rtl/crash_flip_motor_mixer_assert.svh @@
// Assertion helpers for the crash flip motor mixer.
`ifndef CRASH_FLIP_MOTOR_MIXER_ASSERT_SVH
`define CRASH_FLIP_MOTOR_MIXER_ASSERT_SVH

// Same-cycle property, checked at every clock edge outside reset.
`define CFM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/cfm_pkg.sv @@
package cfm_pkg;

  // Fixed field widths
  localparam int IN_W       = 12;
  localparam int OUT_W      = 14;
  localparam int DB_W       = 11;
  localparam int DB_SQ_W    = 2 * DB_W;
  localparam int WGT_W      = 24;
  localparam int W_W        = 8;
  localparam int W_FRAC     = 6;
  localparam int FRAC_BITS  = 10;
  localparam int NUM_MOTORS = 4;

  // Datapath widths
  localparam int MAG_W    = IN_W;            // |x| up to 2048
  localparam int SQR_W    = 2 * IN_W - 1;    // x^2 up to 2^22
  localparam int SQ_W     = 2 * IN_W;        // p^2 + r^2 up to 2^23
  localparam int SUM_W    = IN_W + 1;        // |p| + |r| up to 4096
  localparam int SUM2_W   = 2 * IN_W + 1;    // (|p| + |r|)^2 up to 2^24
  localparam int DIAG_W   = SUM2_W + 1;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int SQRT_PER_STAGE = 3;
  localparam int SQRT_STAGES    = ROOT_W / SQRT_PER_STAGE;
  localparam int MIX_W    = W_W + 2;         // three weights, +-384
  localparam int PROD_W   = ROOT_W + MIX_W + 1;
  localparam int SHIFT_W  = PROD_W - W_FRAC;

  localparam int OUT_MAX = 1 << FRAC_BITS;
  localparam int OUT_MIN = -6 * OUT_MAX;

  localparam int DB_RESET    = 154;
  localparam int DB_SQ_RESET = DB_RESET * DB_RESET;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = WGT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND  = 3'd0,
    REG_MOTOR0_W  = 3'd1,
    REG_MOTOR1_W  = 3'd2,
    REG_MOTOR2_W  = 3'd3,
    REG_MOTOR3_W  = 3'd4
  } cfg_reg_e;

  typedef logic signed [OUT_W-1:0] motor_t;

  // Axis decision carried alongside the square root
  typedef struct packed {
    logic             yaw_act;
    logic             pwr_zero;
    logic [MAG_W-1:0] ya;
    logic             act_y;
    logic             act_p;
    logic             act_r;
    logic             neg_y;
    logic             neg_p;
    logic             neg_r;
  } mix_ctl_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  // One digit of the restoring square root: bring down two radicand bits
  function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a, input logic [1:0] pair);
    logic [REM_W+1:0] rs;
    logic [REM_W+1:0] trial;
    sqrt_acc_t        r;
    rs    = {a.rem, pair};
    trial = (REM_W + 2)'({a.root, 2'b01});
    if (rs >= trial) begin
      r.rem  = REM_W'(rs - trial);
      r.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(rs);
      r.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Signed weight times axis sign: +w for a negative deflection, -w otherwise, zero when the axis is inactive
  function automatic logic signed [MIX_W-1:0] wgt_term(input logic act, input logic neg,
                                                       input logic [W_W-1:0] w);
    logic signed [MIX_W-1:0] ws;
    ws = MIX_W'($signed(w));
    if (!act) begin
      return '0;
    end else if (neg) begin
      return ws;
    end else begin
      return -ws;
    end
  endfunction

endpackage

@@ hw/rtl/cfm_if.sv @@
interface cfm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cfm_pkg::CFG_IDX_W-1:0]    index;
  logic [cfm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface cfm_stick_if;
  logic                             valid;
  logic                             ready;
  logic signed [cfm_pkg::IN_W-1:0]  pitch_deflection;
  logic signed [cfm_pkg::IN_W-1:0]  roll_deflection;
  logic signed [cfm_pkg::IN_W-1:0]  yaw_deflection;

  modport source (output valid, output pitch_deflection, output roll_deflection,
                  output yaw_deflection, input ready);
  modport sink   (input valid, input pitch_deflection, input roll_deflection,
                  input yaw_deflection, output ready);
endinterface

interface cfm_motor_if;
  logic                             valid;
  logic                             ready;
  logic signed [cfm_pkg::OUT_W-1:0] motor0_out;
  logic signed [cfm_pkg::OUT_W-1:0] motor1_out;
  logic signed [cfm_pkg::OUT_W-1:0] motor2_out;
  logic signed [cfm_pkg::OUT_W-1:0] motor3_out;

  modport source (output valid, output motor0_out, output motor1_out,
                  output motor2_out, output motor3_out, input ready);
  modport sink   (input valid, input motor0_out, input motor1_out,
                  input motor2_out, input motor3_out, output ready);
endinterface

@@ hw/rtl/cfm_front.sv @@
// Stick front end: magnitudes and squares, length and diagonal terms,
// then axis selection and deadband decision. Three stages.
module cfm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cfm_pkg::IN_W-1:0]     pitch_i,
  input  logic signed [cfm_pkg::IN_W-1:0]     roll_i,
  input  logic signed [cfm_pkg::IN_W-1:0]     yaw_i,
  input  logic [cfm_pkg::DB_W-1:0]            deadband_i,
  input  logic [cfm_pkg::DB_SQ_W-1:0]         deadband_sq_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [cfm_pkg::SQ_W-1:0]            sq_o,
  output cfm_pkg::mix_ctl_t                   ctl_o
);

  // Stage A
  logic                           va_q;
  logic [cfm_pkg::MAG_W-1:0]      pa_d, ra_d, ya_d;
  logic signed [cfm_pkg::SQ_W-1:0] pp_d, rr_d;
  logic [cfm_pkg::MAG_W-1:0]      ya_a_q;
  logic                           neg_p_a_q, neg_r_a_q, neg_y_a_q;
  logic                           yaw_act_a_q, r_gt_p_a_q;
  logic [cfm_pkg::SUM_W-1:0]      sum_a_q;
  logic [cfm_pkg::SQR_W-1:0]      p2_a_q, r2_a_q;

  // Stage B
  logic                           vb_q;
  logic [cfm_pkg::SQ_W-1:0]       sq_b_d;
  logic [cfm_pkg::SUM2_W-1:0]     sum2_b_d;
  logic [cfm_pkg::SQ_W-1:0]       sq_b_q;
  logic [cfm_pkg::SUM2_W-1:0]     sum2_b_q;
  logic [cfm_pkg::MAG_W-1:0]      ya_b_q;
  logic                           neg_p_b_q, neg_r_b_q, neg_y_b_q;
  logic                           yaw_act_b_q, r_gt_p_b_q;

  // Stage C
  logic                           vc_q;
  logic [cfm_pkg::DIAG_W-1:0]     lhs_d, rhs_d;
  logic                           off_diag_d;
  cfm_pkg::mix_ctl_t              ctl_c_d, ctl_c_q;
  logic [cfm_pkg::SQ_W-1:0]       sq_c_q;

  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c      = ~vc_q | out_ready_i;
  assign rdy_b      = ~vb_q | rdy_c;
  assign rdy_a      = ~va_q | rdy_b;
  assign in_ready_o = rdy_a;

  // A: magnitudes, signs, squares
  always_comb begin
    pa_d = pitch_i[cfm_pkg::IN_W-1] ? cfm_pkg::MAG_W'(-pitch_i) : cfm_pkg::MAG_W'(pitch_i);
    ra_d = roll_i[cfm_pkg::IN_W-1]  ? cfm_pkg::MAG_W'(-roll_i)  : cfm_pkg::MAG_W'(roll_i);
    ya_d = yaw_i[cfm_pkg::IN_W-1]   ? cfm_pkg::MAG_W'(-yaw_i)   : cfm_pkg::MAG_W'(yaw_i);
    pp_d = pitch_i * pitch_i;
    rr_d = roll_i * roll_i;
  end

  // B: length squared and diagonal sum squared
  always_comb begin
    sq_b_d   = cfm_pkg::SQ_W'(p2_a_q) + cfm_pkg::SQ_W'(r2_a_q);
    sum2_b_d = sum_a_q * sum_a_q;
  end

  // C: off diagonal when 2*(|p|+|r|)^2 < 3*(p^2+r^2), or zero length
  always_comb begin
    lhs_d      = {sum2_b_q, 1'b0};
    rhs_d      = cfm_pkg::DIAG_W'(sq_b_q) + cfm_pkg::DIAG_W'({sq_b_q, 1'b0});
    off_diag_d = (sq_b_q == '0) || (lhs_d < rhs_d);

    ctl_c_d.yaw_act = yaw_act_b_q;
    ctl_c_d.ya      = ya_b_q;
    ctl_c_d.neg_y   = neg_y_b_q;
    ctl_c_d.neg_p   = neg_p_b_q;
    ctl_c_d.neg_r   = neg_r_b_q;
    if (yaw_act_b_q) begin
      ctl_c_d.act_y    = 1'b1;
      ctl_c_d.act_p    = 1'b0;
      ctl_c_d.act_r    = 1'b0;
      ctl_c_d.pwr_zero = (ya_b_q <= cfm_pkg::MAG_W'(deadband_i));
    end else begin
      ctl_c_d.act_y    = 1'b0;
      ctl_c_d.act_p    = ~(off_diag_d & r_gt_p_b_q);
      ctl_c_d.act_r    = ~(off_diag_d & ~r_gt_p_b_q);
      ctl_c_d.pwr_zero = (sq_b_q <= cfm_pkg::SQ_W'(deadband_sq_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      ya_a_q      <= ya_d;
      neg_p_a_q   <= pitch_i[cfm_pkg::IN_W-1];
      neg_r_a_q   <= roll_i[cfm_pkg::IN_W-1];
      neg_y_a_q   <= yaw_i[cfm_pkg::IN_W-1];
      yaw_act_a_q <= (ya_d > pa_d) && (ya_d > ra_d);
      r_gt_p_a_q  <= ra_d > pa_d;
      sum_a_q     <= cfm_pkg::SUM_W'(pa_d) + cfm_pkg::SUM_W'(ra_d);
      p2_a_q      <= pp_d[cfm_pkg::SQR_W-1:0];
      r2_a_q      <= rr_d[cfm_pkg::SQR_W-1:0];
    end
    if (rdy_b) begin
      sq_b_q      <= sq_b_d;
      sum2_b_q    <= sum2_b_d;
      ya_b_q      <= ya_a_q;
      neg_p_b_q   <= neg_p_a_q;
      neg_r_b_q   <= neg_r_a_q;
      neg_y_b_q   <= neg_y_a_q;
      yaw_act_b_q <= yaw_act_a_q;
      r_gt_p_b_q  <= r_gt_p_a_q;
    end
    if (rdy_c) begin
      sq_c_q  <= sq_b_q;
      ctl_c_q <= ctl_c_d;
    end
  end

  assign out_valid_o = vc_q;
  assign sq_o        = sq_c_q;
  assign ctl_o       = ctl_c_q;

endmodule

@@ hw/rtl/cfm_sqrt.sv @@
// Pipelined floor square root, three root digits per stage.
module cfm_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cfm_pkg::SQ_W-1:0]      sq_i,
  input  cfm_pkg::mix_ctl_t             ctl_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cfm_pkg::ROOT_W-1:0]    root_o,
  output cfm_pkg::mix_ctl_t             ctl_o
);

  localparam int NS = cfm_pkg::SQRT_STAGES;
  localparam int PS = cfm_pkg::SQRT_PER_STAGE;

  logic                         v_q    [NS];
  logic                         rdy    [NS];
  logic [cfm_pkg::ROOT_W-1:0]   root_q [NS];
  cfm_pkg::mix_ctl_t            ctl_q  [NS];
  logic [cfm_pkg::REM_W-1:0]    rem_q  [NS-1];
  logic [cfm_pkg::SQ_W-1:0]     x_q    [NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                       v_in;
    logic                       rdy_nxt;
    cfm_pkg::sqrt_acc_t         acc_in;
    cfm_pkg::sqrt_acc_t         acc_d;
    logic [cfm_pkg::SQ_W-1:0]   x_in;
    cfm_pkg::mix_ctl_t          ctl_in;

    if (s == 0) begin : g_first
      assign v_in        = in_valid_i;
      assign acc_in      = '0;
      assign x_in        = sq_i;
      assign ctl_in      = ctl_i;
      assign in_ready_o  = rdy[0];
    end else begin : g_mid
      assign v_in        = v_q[s-1];
      assign acc_in.rem  = rem_q[s-1];
      assign acc_in.root = root_q[s-1];
      assign x_in        = x_q[s-1];
      assign ctl_in      = ctl_q[s-1];
    end

    if (s == NS - 1) begin : g_last
      assign rdy_nxt = out_ready_i;
    end else begin : g_next
      assign rdy_nxt = rdy[s+1];
      always_ff @(posedge clk_i) begin
        if (rdy[s]) begin
          rem_q[s] <= acc_d.rem;
          x_q[s]   <= x_in;
        end
      end
    end

    assign rdy[s] = ~v_q[s] | rdy_nxt;

    always_comb begin
      acc_d = acc_in;
      for (int j = 0; j < PS; j++) begin
        acc_d = cfm_pkg::sqrt_step(acc_d, x_in[cfm_pkg::SQ_W-1-2*(s*PS+j) -: 2]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        root_q[s] <= acc_d.root;
        ctl_q[s]  <= ctl_in;
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign root_o      = root_q[NS-1];
  assign ctl_o       = ctl_q[NS-1];

endmodule

@@ hw/rtl/cfm_mix.sv @@
// Motor mix: power and weight sums, product, floor shift and clamp.
module cfm_mix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cfm_pkg::ROOT_W-1:0]    root_i,
  input  cfm_pkg::mix_ctl_t             ctl_i,
  input  logic [cfm_pkg::WGT_W-1:0]     weights_i [cfm_pkg::NUM_MOTORS],
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cfm_pkg::motor_t               motor_o [cfm_pkg::NUM_MOTORS]
);

  localparam int NM = cfm_pkg::NUM_MOTORS;

  logic                               v1_q, v2_q, v3_q;
  logic                               rdy1, rdy2, rdy3;
  logic [cfm_pkg::ROOT_W-1:0]         power_d, power_q;
  logic signed [cfm_pkg::MIX_W-1:0]   mix_d  [NM];
  logic signed [cfm_pkg::MIX_W-1:0]   mix_q  [NM];
  logic signed [cfm_pkg::PROD_W-1:0]  prod_d [NM];
  logic signed [cfm_pkg::PROD_W-1:0]  prod_q [NM];
  logic signed [cfm_pkg::SHIFT_W-1:0] sh     [NM];
  cfm_pkg::motor_t                    out_d  [NM];
  cfm_pkg::motor_t                    out_q  [NM];

  assign rdy3       = ~v3_q | out_ready_i;
  assign rdy2       = ~v2_q | rdy3;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    if (ctl_i.pwr_zero) begin
      power_d = '0;
    end else if (ctl_i.yaw_act) begin
      power_d = ctl_i.ya;
    end else begin
      power_d = root_i;
    end
    for (int m = 0; m < NM; m++) begin
      // weights: yaw [7:0], pitch [15:8], roll [23:16]
      mix_d[m] = cfm_pkg::wgt_term(ctl_i.act_y, ctl_i.neg_y, weights_i[m][7:0])
               + cfm_pkg::wgt_term(ctl_i.act_p, ctl_i.neg_p, weights_i[m][15:8])
               + cfm_pkg::wgt_term(ctl_i.act_r, ctl_i.neg_r, weights_i[m][23:16]);
    end
  end

  always_comb begin
    for (int m = 0; m < NM; m++) begin
      prod_d[m] = $signed({1'b0, power_q}) * mix_q[m];
    end
  end

  // Q16 -> Q10 by flooring, then clamp
  always_comb begin
    for (int m = 0; m < NM; m++) begin
      sh[m] = prod_q[m][cfm_pkg::PROD_W-1:cfm_pkg::W_FRAC];
      if (sh[m] > cfm_pkg::OUT_MAX) begin
        out_d[m] = cfm_pkg::OUT_W'(cfm_pkg::OUT_MAX);
      end else if (sh[m] < cfm_pkg::OUT_MIN) begin
        out_d[m] = cfm_pkg::OUT_W'(cfm_pkg::OUT_MIN);
      end else begin
        out_d[m] = sh[m][cfm_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      power_q <= power_d;
      mix_q   <= mix_d;
    end
    if (rdy2) prod_q <= prod_d;
    if (rdy3) out_q  <= out_d;
  end

  assign out_valid_o = v3_q;
  assign motor_o     = out_q;

endmodule

@@ hw/rtl/crash_flip_motor_mixer.sv @@
// Crash flip motor mixer.
// stick_i (sink): one word of signed Q1.10 pitch, roll and yaw deflections.
// motor_o (source): one word of four signed Q10 motor drive fractions,
//   each clamped to at most 1.0 and saturated at -6.0.
// cfg_i (sink): register writes, index 0 deadband, 1..4 motor weights;
//   always ready, unknown indexes ignored. Write only while the mixer is idle.
// Pipeline: 3 front-end stages, 4 square-root stages at 3 root bits each, 3 mix stages.
// Throughput: one word per cycle while motor_o is ready; every stage has its own valid bit and
//   advances when empty or when its successor moves, so bubbles collapse.
// Stall: a held motor word freezes only the stages behind it; stick_i keeps
//   accepting until every stage is full. Nothing is dropped or repeated.
// Reset: all valid bits clear, deadband returns to 154, weights to zero.
module crash_flip_motor_mixer (
  input logic         clk_i,
  input logic         rst_ni,
  cfm_cfg_if.sink     cfg_i,
  cfm_stick_if.sink   stick_i,
  cfm_motor_if.source motor_o
);

  `include "crash_flip_motor_mixer_assert.svh"

  localparam int NM = cfm_pkg::NUM_MOTORS;

  // Config registers; deadband square cached for the length test
  logic [cfm_pkg::DB_W-1:0]     db_q;
  logic [cfm_pkg::DB_SQ_W-1:0]  db_sq_q;
  logic [cfm_pkg::WGT_W-1:0]    wgt_q [NM];

  // Front end -> square root
  logic                         fe_valid, fe_ready;
  logic [cfm_pkg::SQ_W-1:0]     fe_sq;
  cfm_pkg::mix_ctl_t            fe_ctl;

  // Square root -> mix
  logic                         sr_valid, sr_ready;
  logic [cfm_pkg::ROOT_W-1:0]   sr_root;
  cfm_pkg::mix_ctl_t            sr_ctl;

  cfm_pkg::motor_t              motors [NM];
  logic                         out_in_range;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q    <= cfm_pkg::DB_W'(cfm_pkg::DB_RESET);
      db_sq_q <= cfm_pkg::DB_SQ_W'(cfm_pkg::DB_SQ_RESET);
      wgt_q   <= '{default: '0};
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        cfm_pkg::REG_DEADBAND: begin
          db_q    <= cfg_i.data[cfm_pkg::DB_W-1:0];
          db_sq_q <= cfg_i.data[cfm_pkg::DB_W-1:0] * cfg_i.data[cfm_pkg::DB_W-1:0];
        end
        cfm_pkg::REG_MOTOR0_W: wgt_q[0] <= cfg_i.data;
        cfm_pkg::REG_MOTOR1_W: wgt_q[1] <= cfg_i.data;
        cfm_pkg::REG_MOTOR2_W: wgt_q[2] <= cfg_i.data;
        cfm_pkg::REG_MOTOR3_W: wgt_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  cfm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (stick_i.valid),
    .in_ready_o    (stick_i.ready),
    .pitch_i       (stick_i.pitch_deflection),
    .roll_i        (stick_i.roll_deflection),
    .yaw_i         (stick_i.yaw_deflection),
    .deadband_i    (db_q),
    .deadband_sq_i (db_sq_q),
    .out_valid_o   (fe_valid),
    .out_ready_i   (fe_ready),
    .sq_o          (fe_sq),
    .ctl_o         (fe_ctl)
  );

  cfm_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fe_valid),
    .in_ready_o  (fe_ready),
    .sq_i        (fe_sq),
    .ctl_i       (fe_ctl),
    .out_valid_o (sr_valid),
    .out_ready_i (sr_ready),
    .root_o      (sr_root),
    .ctl_o       (sr_ctl)
  );

  cfm_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sr_valid),
    .in_ready_o  (sr_ready),
    .root_i      (sr_root),
    .ctl_i       (sr_ctl),
    .weights_i   (wgt_q),
    .out_valid_o (motor_o.valid),
    .out_ready_i (motor_o.ready),
    .motor_o     (motors)
  );

  assign motor_o.motor0_out = motors[0];
  assign motor_o.motor1_out = motors[1];
  assign motor_o.motor2_out = motors[2];
  assign motor_o.motor3_out = motors[3];

  always_comb begin
    out_in_range = 1'b1;
    for (int m = 0; m < NM; m++) begin
      if (motors[m] > cfm_pkg::OUT_MAX || motors[m] < cfm_pkg::OUT_MIN) begin
        out_in_range = 1'b0;
      end
    end
  end

  // Clamp stage must keep every drive within [-6.0, 1.0]
  `CFM_ASSERT(a_out_range, clk_i, rst_ni, !motor_o.valid || out_in_range, "motor drive out of range")

  // With the sink ready, every stage drains, so the stick side must be ready
  `CFM_ASSERT(a_flow_ready, clk_i, rst_ni, !motor_o.ready || stick_i.ready, "stick stalled with open sink")

  // Cached deadband square follows a deadband write
  `CFM_ASSERT_NEXT(a_db_sq, clk_i, rst_ni, cfg_i.valid && cfg_i.ready && cfg_i.index == cfm_pkg::REG_DEADBAND, db_sq_q == cfm_pkg::DB_SQ_W'(db_q) * cfm_pkg::DB_SQ_W'(db_q), "deadband square stale")

endmodule
